// ----- design/rts_pkg.sv -----
`default_nettype none

package rts_pkg;

	// pipeline depth, accept to result register
	localparam int STAGES = 7;

	typedef logic [5:0] coord_t;
	typedef logic [7:0] chan_t;
	typedef logic [2:0][7:0] rgb_t;   // [0] red, [1] green, [2] blue
	typedef logic [STAGES:1] stage_en_t;

	// tile geometry
	localparam int MARGIN = 2;
	localparam int CORNER = 12;

	// vertical ramp, percent
	localparam int RAMP_LOW = 84;
	localparam int RAMP_SPAN = 22;

	// glow
	localparam int GLOW_X = 36;
	localparam int GLOW_Y = 11;
	localparam int GLOW_R = 20;
	localparam int GLOW_R2 = GLOW_R * GLOW_R;
	localparam int GLOW_MAX = 34;
	// glow = n*34/400 == n*17/200
	localparam logic [4:0] GLOW_NUM = 5'(GLOW_MAX / 2);

	// rim
	localparam logic [5:0] RIM_AMOUNT = 6'd18;
	localparam rgb_t RIM_WHITE = '{8'd255, 8'd249, 8'd246};

	localparam logic [6:0] PCT_FULL = 7'd100;

	localparam rgb_t BASE_RESET = '{8'd157, 8'd105, 8'd17};
	localparam rgb_t ACCENT_RESET = '{8'd229, 8'd205, 8'd69};

	typedef enum logic [2:0] {
		REG_BASE_RED,
		REG_BASE_GREEN,
		REG_BASE_BLUE,
		REG_ACCENT_RED,
		REG_ACCENT_GREEN,
		REG_ACCENT_BLUE
	} cfg_reg_t;

	typedef struct packed {
		logic cov;
		logic rim;
	} pix_ctl_t;

	typedef struct packed {
		pix_ctl_t   ctl;
		logic [8:0] glow_n;   // 400 - d2 inside the glow disc, else 0
		logic [6:0] ramp;     // brightness percent
	} geom_t;

	// floor(m/100) for m < 43690: multiply by ceil(2^19/100)
	function automatic logic [8:0] div100(input logic [14:0] m);
		logic [27:0] p;
		p = m * 13'd5243;
		return p[27:19];
	endfunction

	// floor(m/200) for m < 43690: multiply by ceil(2^21/200)
	function automatic logic [5:0] div200(input logic [12:0] m);
		logic [26:0] p;
		p = m * 14'd10486;
		return p[26:21];
	endfunction

	// point inside a rounded box [lo,hi]^2 with corner radius r
	function automatic logic in_rounded(input coord_t x, input coord_t y,
			input int lo, input int hi, input int r);
		logic signed [7:0] dx;
		logic signed [7:0] dy;
		logic signed [15:0] dx2;
		logic signed [15:0] dy2;
		logic box;
		box = (int'(x) >= lo) && (int'(x) <= hi) && (int'(y) >= lo) && (int'(y) <= hi);
		if (int'(x) < lo + r) begin
			dx = $signed({2'b00, x}) - 8'(lo + r);
		end else if (int'(x) > hi - r) begin
			dx = $signed({2'b00, x}) - 8'(hi - r);
		end else begin
			dx = '0;
		end
		if (int'(y) < lo + r) begin
			dy = $signed({2'b00, y}) - 8'(lo + r);
		end else if (int'(y) > hi - r) begin
			dy = $signed({2'b00, y}) - 8'(hi - r);
		end else begin
			dy = '0;
		end
		dx2 = dx * dx;
		dy2 = dy * dy;
		return box && ((dx2 + dy2) <= 16'(r * r));
	endfunction

endpackage

`default_nettype wire

// ----- design/rts_if.sv -----
`default_nettype none

interface rts_pixel_if import rts_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t pixel_x;
	coord_t pixel_y;

	modport source (output valid, output pixel_x, output pixel_y, input ready);
	modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface rts_shade_if import rts_pkg::*; ();
	logic  valid;
	logic  ready;
	logic  covered;
	chan_t alpha;
	chan_t red;
	chan_t green;
	chan_t blue;

	modport source (output valid, output covered, output alpha, output red,
		output green, output blue, input ready);
	modport sink (input valid, input covered, input alpha, input red,
		input green, input blue, output ready);
endinterface

interface rts_cfg_if import rts_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [2:0] index;
	chan_t      data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- design/rts_cfg.sv -----
`default_nettype none

module rts_cfg import rts_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	rts_cfg_if.sink   cfg,
	output rgb_t      base,
	output rgb_t      accent
);

	rgb_t base_q;
	rgb_t accent_q;

	assign cfg.ready = 1'b1;
	assign base = base_q;
	assign accent = accent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
			accent_q <= ACCENT_RESET;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_BASE_RED:     base_q[0] <= cfg.data;
				REG_BASE_GREEN:   base_q[1] <= cfg.data;
				REG_BASE_BLUE:    base_q[2] <= cfg.data;
				REG_ACCENT_RED:   accent_q[0] <= cfg.data;
				REG_ACCENT_GREEN: accent_q[1] <= cfg.data;
				REG_ACCENT_BLUE:  accent_q[2] <= cfg.data;
				default: ;   // unused index, dropped
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- design/rts_geom.sv -----
`default_nettype none

module rts_geom import rts_pkg::*; #(
	parameter int TILE_SIZE = 48
) (
	input  wire logic   clk,
	input  wire logic   en,
	input  wire coord_t pixel_x,
	input  wire coord_t pixel_y,
	output geom_t       geom_s1
);

	localparam int LO = MARGIN;
	localparam int HI = TILE_SIZE - MARGIN - 1;

	// ramp percent per row, folded at elaboration
	logic [6:0] ramp_lut [64];

	for (genvar i = 0; i < 64; i++) begin : g_ramp
		localparam int ROW = (i < LO) ? 0 : i - LO;
		localparam int RV = RAMP_LOW + (ROW * RAMP_SPAN) / (HI - LO);
		assign ramp_lut[i] = 7'(RV);
	end

	logic              outer;
	logic              inner;
	logic signed [6:0] dx;
	logic signed [6:0] dy;
	logic signed [13:0] dx2;
	logic signed [13:0] dy2;
	logic [11:0]       d2;
	logic [8:0]        glow_n;

	always_comb begin
		outer = in_rounded(pixel_x, pixel_y, LO, HI, CORNER);
		inner = in_rounded(pixel_x, pixel_y, LO + 1, HI - 1, CORNER - 1);
		dx = $signed({1'b0, pixel_x}) - 7'(GLOW_X);
		dy = $signed({1'b0, pixel_y}) - 7'(GLOW_Y);
		dx2 = dx * dx;
		dy2 = dy * dy;
		d2 = dx2[11:0] + dy2[11:0];
		if (int'(d2) < GLOW_R2) begin
			glow_n = 9'(GLOW_R2 - int'(d2));
		end else begin
			glow_n = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geom_s1.ctl.cov <= outer;
			geom_s1.ctl.rim <= !inner;
			geom_s1.glow_n <= glow_n;
			geom_s1.ramp <= ramp_lut[pixel_y];
		end
	end

endmodule

`default_nettype wire

// ----- design/rts_glow.sv -----
`default_nettype none

module rts_glow import rts_pkg::*; (
	input  wire logic      clk,
	input  wire stage_en_t stage_en,
	input  wire logic [8:0] glow_n_s1,
	output logic [5:0]     glow_s3
);

	logic [12:0] gm_s2;

	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			gm_s2 <= glow_n_s1 * GLOW_NUM;
		end
		if (stage_en[3]) begin
			glow_s3 <= div200(gm_s2);
		end
	end

endmodule

`default_nettype wire

// ----- design/rts_mix.sv -----
`default_nettype none

// (a*(100-amt) + b*amt) / 100, two stages
module rts_mix import rts_pkg::*; (
	input  wire logic       clk,
	input  wire logic       en_sum,
	input  wire logic       en_div,
	input  wire chan_t      a,
	input  wire chan_t      b,
	input  wire logic [5:0] amt,
	output chan_t           res
);

	logic [6:0]  keep;
	logic [14:0] sum_s1;
	logic [8:0]  quo;
	chan_t       res_s2;

	assign keep = PCT_FULL - 7'(amt);
	assign quo = div100(sum_s1);
	assign res = res_s2;

	always_ff @(posedge clk) begin
		if (en_sum) begin
			sum_s1 <= a * keep + b * amt;
		end
		if (en_div) begin
			res_s2 <= quo[7:0];   // sum <= 25500, quotient fits
		end
	end

endmodule

`default_nettype wire

// ----- design/rts_chan.sv -----
`default_nettype none

// one color channel: ramp scale, glow blend, rim blend
module rts_chan import rts_pkg::*; (
	input  wire logic       clk,
	input  wire stage_en_t  stage_en,
	input  wire chan_t      base,
	input  wire chan_t      accent,
	input  wire chan_t      white,
	input  wire logic [6:0] ramp_s1,
	input  wire logic [5:0] glow_s3,
	input  wire logic [5:0] rim_amt_s5,
	output chan_t           shade_s7
);

	logic [14:0] prod_s2;
	logic [8:0]  scaled;
	chan_t       lit_s3;
	chan_t       glow_c_s5;

	assign scaled = div100(prod_s2);

	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			prod_s2 <= base * ramp_s1;
		end
		if (stage_en[3]) begin
			lit_s3 <= scaled[8] ? 8'hFF : scaled[7:0];   // saturate above 255
		end
	end

	// glow amount 0 outside the disc leaves the value unchanged
	rts_mix u_glow (
		.clk    (clk),
		.en_sum (stage_en[4]),
		.en_div (stage_en[5]),
		.a      (lit_s3),
		.b      (accent),
		.amt    (glow_s3),
		.res    (glow_c_s5)
	);

	rts_mix u_rim (
		.clk    (clk),
		.en_sum (stage_en[6]),
		.en_div (stage_en[7]),
		.a      (glow_c_s5),
		.b      (white),
		.amt    (rim_amt_s5),
		.res    (shade_s7)
	);

endmodule

`default_nettype wire

// ----- design/rounded_tile_pixel_shader.sv -----
`default_nettype none

// Rounded tile pixel shader.
// pixel (sink): one item per pixel, pixel_x / pixel_y inside a TILE_SIZE square.
// shade (source): one item per pixel item, in order: covered, alpha and RGB of
//   the tile background; all zero for pixels outside the rounded tile.
// cfg (sink): register writes, index 0..2 base RGB, 3..5 accent RGB; always
//   ready, unused indexes dropped. Write only while no item is in flight.
// Path: an accepted pixel moves through the stage registers in order; shade
//   valid is the last stage's valid bit, taken while shade.ready is high.
// Throughput: one item per clock while shade.ready is high; every stage is one
//   register step (geometry, scale mult, /100, blend mult, /100, rim mult, /100).
// Stall: each stage loads when it is empty or the stage after it moves, so a
//   stalled shade port fills the bubbles first, then drops pixel.ready. Nothing
//   is lost or repeated.
// Reset: arst_n clears all valid bits and loads the default colors
//   (base 17/105/157, accent 69/205/229).
module rounded_tile_pixel_shader import rts_pkg::*; #(
	parameter int TILE_SIZE = 48
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	rts_pixel_if.sink   pixel,
	rts_shade_if.source shade,
	rts_cfg_if.sink     cfg
);

	rgb_t       base;
	rgb_t       accent;
	stage_en_t  stage_en;
	logic [STAGES:1] vld_q;
	geom_t      geom_s1;
	logic [5:0] glow_s3;
	logic [5:0] rim_amt_s5;
	rgb_t       shade_s7;

	// coverage / rim flags ride along beside the color path
	pix_ctl_t   ctl_s2;
	pix_ctl_t   ctl_s3;
	pix_ctl_t   ctl_s4;
	pix_ctl_t   ctl_s5;
	pix_ctl_t   ctl_s6;
	pix_ctl_t   ctl_s7;

	rts_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.base   (base),
		.accent (accent)
	);

	// stage k loads when empty or when stage k+1 is moving on
	always_comb begin
		stage_en[STAGES] = !vld_q[STAGES] || shade.ready;
		for (int k = STAGES - 1; k >= 1; k--) begin
			stage_en[k] = !vld_q[k] || stage_en[k + 1];
		end
	end

	assign pixel.ready = stage_en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (stage_en & {vld_q[STAGES-1:1], pixel.valid}) | (~stage_en & vld_q);
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[2]) ctl_s2 <= geom_s1.ctl;
		if (stage_en[3]) ctl_s3 <= ctl_s2;
		if (stage_en[4]) ctl_s4 <= ctl_s3;
		if (stage_en[5]) ctl_s5 <= ctl_s4;
		if (stage_en[6]) ctl_s6 <= ctl_s5;
		if (stage_en[7]) ctl_s7 <= ctl_s6;
	end

	rts_geom #(
		.TILE_SIZE (TILE_SIZE)
	) u_geom (
		.clk     (clk),
		.en      (stage_en[1]),
		.pixel_x (pixel.pixel_x),
		.pixel_y (pixel.pixel_y),
		.geom_s1 (geom_s1)
	);

	rts_glow u_glow (
		.clk       (clk),
		.stage_en  (stage_en),
		.glow_n_s1 (geom_s1.glow_n),
		.glow_s3   (glow_s3)
	);

	assign rim_amt_s5 = ctl_s5.rim ? RIM_AMOUNT : 6'd0;

	for (genvar c = 0; c < 3; c++) begin : g_chan
		rts_chan u_chan (
			.clk        (clk),
			.stage_en   (stage_en),
			.base       (base[c]),
			.accent     (accent[c]),
			.white      (RIM_WHITE[c]),
			.ramp_s1    (geom_s1.ramp),
			.glow_s3    (glow_s3),
			.rim_amt_s5 (rim_amt_s5),
			.shade_s7   (shade_s7[c])
		);
	end

	// outside the tile everything reads as transparent zero
	assign shade.valid = vld_q[STAGES];
	assign shade.covered = ctl_s7.cov;
	assign shade.alpha = ctl_s7.cov ? 8'hFF : 8'h00;
	assign shade.red = ctl_s7.cov ? shade_s7[0] : 8'h00;
	assign shade.green = ctl_s7.cov ? shade_s7[1] : 8'h00;
	assign shade.blue = ctl_s7.cov ? shade_s7[2] : 8'h00;

	// accepted pixel occupies the first stage next cycle
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel.valid && pixel.ready) |=> vld_q[1])
		else $error("accepted item missing from first stage");

	// full pipeline behind a stalled output must refuse input
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		((&vld_q) && !shade.ready) |-> !pixel.ready)
		else $error("input accepted while pipeline full and stalled");

	// glow blend never exceeds its maximum percent
	a_glow_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[3] |-> (int'(glow_s3) <= GLOW_MAX))
		else $error("glow amount out of range");

	// a result held at a stalled output keeps its stage valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[STAGES] && !shade.ready) |=> (vld_q[STAGES] && $stable(ctl_s7)))
		else $error("stalled result dropped");

endmodule

`default_nettype wire
